>>> rtl/core/lfs_pkg.sv
// Shared types and constants of the length-prefixed frame splitter.
package lfs_pkg;

  localparam logic [7:0] TYPE_SHORT = 8'hC1;
  localparam logic [7:0] TYPE_LONG = 8'hC2;

  localparam logic [15:0] HDR_SHORT = 16'd3;
  localparam logic [15:0] HDR_LONG = 16'd4;

  localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BAD_TYPE = 2'd1;
  localparam logic [1:0] ERR_BAD_LEN = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  cmd;
    logic [15:0] len;
    logic        hdr;
    logic        long_hdr;
    logic        last;
    logic [1:0]  err;
  } job_t;

endpackage

>>> rtl/core/lfs_front.sv
// Front part: parses the byte stream and issues release jobs.
module lfs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  input  logic          cfg_write,
  input  logic [15:0]   cfg_data,
  output logic          job_push,
  output lfs_pkg::job_t job
);
  import lfs_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE, PH_LEN_A, PH_LEN_B, PH_CMD, PH_BODY, PH_DEAD
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic        long_header;
  logic [15:0] length_reg;
  logic [15:0] bytes_seen;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [7:0]  held2;
  logic [7:0]  command_reg;
  logic [15:0] max_len;
  logic [15:0] hdr_len;
  logic [15:0] seen_next;
  logic        bad_len;
  logic        body_last;

  assign hdr_len = long_header ? HDR_LONG : HDR_SHORT;
  assign seen_next = bytes_seen + 16'd1;
  assign bad_len = (length_reg < hdr_len) || (length_reg > max_len);
  assign body_last = (seen_next >= length_reg);

  always_comb begin
    job_push = 1'b0;
    job = '0;
    phase_next = phase;
    case (phase)
      PH_TYPE: begin
        if (rx_byte == TYPE_SHORT || rx_byte == TYPE_LONG) begin
          phase_next = PH_LEN_A;
        end else begin
          job_push = accept;
          job.b0 = rx_byte;
          job.last = 1'b1;
          job.err = ERR_BAD_TYPE;
          phase_next = PH_DEAD;
        end
      end
      PH_LEN_A: begin
        phase_next = long_header ? PH_LEN_B : PH_CMD;
      end
      PH_LEN_B: begin
        phase_next = PH_CMD;
      end
      PH_CMD: begin
        job_push = accept;
        job.cmd = rx_byte;
        job.len = length_reg;
        if (bad_len) begin
          job.b0 = held0;
          job.last = 1'b1;
          job.err = ERR_BAD_LEN;
          phase_next = PH_DEAD;
        end else begin
          job.b0 = held0;
          job.b1 = held1;
          job.b2 = held2;
          job.b3 = rx_byte;
          job.hdr = 1'b1;
          job.long_hdr = long_header;
          job.last = (length_reg == hdr_len);
          job.err = ERR_NONE;
          phase_next = (length_reg == hdr_len) ? PH_TYPE : PH_BODY;
        end
      end
      PH_BODY: begin
        job_push = accept;
        job.b0 = rx_byte;
        job.cmd = command_reg;
        job.len = length_reg;
        job.last = body_last;
        job.err = ERR_NONE;
        phase_next = body_last ? PH_TYPE : PH_BODY;
      end
      default: begin
        phase_next = PH_DEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
      long_header <= 1'b0;
      length_reg <= '0;
      bytes_seen <= '0;
      command_reg <= '0;
      max_len <= MAX_LEN_RESET;
    end else begin
      if (cfg_write) begin
        max_len <= cfg_data;
      end
      if (accept) begin
        phase <= phase_next;
        case (phase)
          PH_TYPE: begin
            long_header <= (rx_byte == TYPE_LONG);
          end
          PH_LEN_A: begin
            length_reg <= long_header ? {rx_byte, 8'h00} : {8'h00, rx_byte};
          end
          PH_LEN_B: begin
            length_reg <= length_reg | {8'h00, rx_byte};
          end
          PH_CMD: begin
            command_reg <= rx_byte;
            if (!bad_len) begin
              bytes_seen <= hdr_len;
            end
          end
          PH_BODY: begin
            bytes_seen <= seen_next;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        PH_TYPE: held0 <= rx_byte;
        PH_LEN_A: held1 <= rx_byte;
        PH_LEN_B: held2 <= rx_byte;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/lfs_queue.sv
// Short job queue between the front and back parts.
module lfs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lfs_pkg::job_t wr_job,
  input  logic          rd_en,
  output lfs_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);
  import lfs_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !rd_en |-> !wr_en)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !rd_en)
    else $error("job queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("job queue count out of range");
`endif

endmodule

>>> rtl/core/lfs_back.sv
// Back part: expands jobs into result items, one per cycle while pop is high.
module lfs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  lfs_pkg::job_t q_job,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    frame_byte,
  output logic [7:0]    command_code,
  output logic [15:0]   frame_length,
  output logic          first_flag,
  output logic          last_flag,
  output logic [1:0]    error_code
);
  import lfs_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] idx;
  logic [1:0] idx_last;
  logic       at_end;
  logic       take;

  assign idx_last = cur.hdr ? (cur.long_hdr ? 2'd3 : 2'd2) : 2'd0;
  assign at_end = (idx == idx_last);
  assign take = pop && busy;
  assign q_pop = !q_empty && (!busy || (take && at_end));
  assign empty = !busy;

  always_comb begin
    case (idx)
      2'd0: frame_byte = cur.b0;
      2'd1: frame_byte = cur.b1;
      2'd2: frame_byte = cur.long_hdr ? cur.b2 : cur.b3;
      default: frame_byte = cur.b3;
    endcase
  end

  assign command_code = cur.cmd;
  assign frame_length = cur.len;
  assign first_flag = cur.hdr && (idx == 2'd0);
  assign last_flag = cur.last && at_end;
  assign error_code = cur.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (take) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

`ifndef ASSERT_OFF
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= idx_last)
    else $error("item index past end of job");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !q_empty |=> busy && idx == 2'd0)
    else $error("waiting job not loaded");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    busy && !pop |=> busy && $stable(idx))
    else $error("result item changed while stalled");
`endif

endmodule

>>> rtl/core/length_prefixed_frame_splitter.sv
// Top level of the length-prefixed frame splitter.
// Takes one received byte per cycle while full is low and gives one result item per
// cycle while pop is high. The front parser releases a frame's header (3 or 4 items)
// when the command byte arrives; a 4-entry job queue and the back expander absorb that
// burst, so with pop held high the sustained rate is one byte per cycle in and out,
// set by the one-item-per-cycle back expander. Each job passes through the queue and the
// back expander's job register before its items reach the ports. A bad type byte or an
// out-of-range length gives one error item and the block then discards input until reset.
// cfg_ready is always high; a new maximum length applies from the next length check.
module length_prefixed_frame_splitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte,
  output logic [7:0]  command_code,
  output logic [15:0] frame_length,
  output logic        first_flag,
  output logic        last_flag,
  output logic [1:0]  error_code
);
  import lfs_pkg::*;

  logic accept;
  logic job_push;
  job_t job;
  job_t q_job;
  logic q_empty;
  logic q_pop;

  assign cfg_ready = 1'b1;
  assign accept = push && !full;

  lfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job       (job)
  );

  lfs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (job),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .full   (full),
    .empty  (q_empty)
  );

  lfs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_job        (q_job),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .frame_byte   (frame_byte),
    .command_code (command_code),
    .frame_length (frame_length),
    .first_flag   (first_flag),
    .last_flag    (last_flag),
    .error_code   (error_code)
  );

endmodule
